// ===== rtl/icfl_pkg.sv =====
// ----------------------------------------------------------------------------
// icfl_pkg: shared types and codes of the inode cache table
// Word layouts of the request and response channels, command codes and the
// request word for the bucket remainder unit.
// ----------------------------------------------------------------------------
`default_nettype none

package icfl_pkg;

   localparam int NUM_W   = 32;
   localparam int IDX_W   = 6;
   localparam int CMD_W   = 3;
   localparam int DIGIT_W = 4;
   localparam int DIGITS  = NUM_W / DIGIT_W;

   localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [NUM_W-1:0] inode_number;
      logic [IDX_W-1:0] entry_index;
   } req_type;

   typedef struct packed {
      logic             success;
      logic [IDX_W-1:0] result_entry;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } fin_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] value;
   } mod_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/inode_cache_hash_free_list.sv =====
// Steps, accepting edge to rsp_valid rising: allocate takes the free-list head
// off the list and patches its neighbors (on an empty list it answers at once);
// insert and remove wait on the remainder unit, which dominates, then push the
// entry on its bucket head or unlink it from its chain; release appends at the
// free-list tail, then unlinks a member; lookup walks the chain and takes a hit
// off the free list; a rejected word answers at once or after reading its links.
// One word at a time. Reset: synchronous; a clearing pass then writes the link
// and bucket RAMs at max(ENTRIES, BUCKETS) addresses while req_stall stays high.
`default_nettype none

// ----------------------------------------------------------------------------
// inode_cache_hash_free_list: hashed inode cache table with FIFO free list
// Pool of ENTRIES entries, BUCKETS chains; lookup, allocate, insert, remove
// and release, one response word per request word.
// ----------------------------------------------------------------------------
module inode_cache_hash_free_list #(
   parameter int ENTRIES = 64,
   parameter int BUCKETS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire icfl_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output icfl_pkg::rsp_type      rsp_data
);

   import icfl_pkg::*;

   // pointer width holds the null link, which is the value ENTRIES
   localparam int IW = $clog2(ENTRIES + 1);
   localparam int EW = $clog2(ENTRIES);
   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int LW = 4 * IW + 2;

   fin_type          fin;
   mod_cmd_type      mod_cmd;
   logic             mod_busy;
   logic [BW-1:0]    mod_rem;
   logic             link_we;
   logic [EW-1:0]    link_waddr;
   logic [LW-1:0]    link_wdata;
   logic [EW-1:0]    link_raddr;
   logic [LW-1:0]    link_rdata;
   logic             tag_we;
   logic [NUM_W-1:0] tag_wdata;
   logic [NUM_W-1:0] tag_rdata;
   logic             bkt_we;
   logic [BW-1:0]    bkt_waddr;
   logic [IW-1:0]    bkt_wdata;
   logic [BW-1:0]    bkt_raddr;
   logic [IW-1:0]    bkt_rdata;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic             rsp_free;

   // Sequencer: decodes the word, walks chains, patches links.
   icfl_ctrl #(
      .ENTRIES (ENTRIES),
      .BUCKETS (BUCKETS),
      .IW      (IW),
      .EW      (EW),
      .BW      (BW),
      .LW      (LW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .fin        (fin),
      .rsp_free   (rsp_free),
      .mod_cmd    (mod_cmd),
      .mod_busy   (mod_busy),
      .mod_rem    (mod_rem),
      .link_we    (link_we),
      .link_waddr (link_waddr),
      .link_wdata (link_wdata),
      .link_raddr (link_raddr),
      .link_rdata (link_rdata),
      .tag_we     (tag_we),
      .tag_wdata  (tag_wdata),
      .tag_rdata  (tag_rdata),
      .bkt_we     (bkt_we),
      .bkt_waddr  (bkt_waddr),
      .bkt_wdata  (bkt_wdata),
      .bkt_raddr  (bkt_raddr),
      .bkt_rdata  (bkt_rdata)
   );

   // Shared remainder unit: bucket of a number on lookup, insert and unlink.
   icfl_mod #(
      .BUCKETS (BUCKETS),
      .BW      (BW)
   ) u_mod (
      .clock (clock),
      .reset (reset),
      .cmd   (mod_cmd),
      .busy  (mod_busy),
      .rem   (mod_rem)
   );

   // Per-entry links and membership flags; written by the clearing pass.
   icfl_ram #(
      .WIDTH (LW),
      .DEPTH (ENTRIES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   // Tags: only read for table members, so never cleared.
   // Read in step with the link RAM at the same entry.
   icfl_ram #(
      .WIDTH (NUM_W),
      .DEPTH (ENTRIES)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (link_waddr),
      .wr_data (tag_wdata),
      .rd_addr (link_raddr),
      .rd_data (tag_rdata)
   );

   // Bucket heads.
   icfl_ram #(
      .WIDTH (IW),
      .DEPTH (BUCKETS)
   ) u_bkt_ram (
      .clock   (clock),
      .wr_en   (bkt_we),
      .wr_addr (bkt_waddr),
      .wr_data (bkt_wdata),
      .rd_addr (bkt_raddr),
      .rd_data (bkt_rdata)
   );

   // Output register: hold the word until taken; the sequencer only
   // finishes into a free slot.
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (fin.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = fin.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // a finished word always lands in an empty output register
   a_fin_into_empty: assert property (@(posedge clock) disable iff (reset)
      fin.valid |-> !rsp_valid_ff)
      else $error("response overwrote a word not yet taken");

   // a result appears only after the request side was held busy
   a_fin_after_busy: assert property (@(posedge clock) disable iff (reset)
      fin.valid |-> $past(req_stall))
      else $error("result without a word in work");

   // the clearing pass keeps requests out right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> req_stall)
      else $error("request taken before the clearing pass");
`endif

endmodule

`default_nettype wire

// ===== rtl/icfl_ram.sv =====
// ----------------------------------------------------------------------------
// icfl_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module icfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/icfl_mod.sv =====
// ----------------------------------------------------------------------------
// icfl_mod: bucket remainder unit
// Computes a number modulo BUCKETS, four bits per cycle, restoring style.
// ----------------------------------------------------------------------------
`default_nettype none

module icfl_mod #(
   parameter int BUCKETS = 16,
   parameter int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire icfl_pkg::mod_cmd_type cmd,
   output logic                      busy,
   output logic [BW-1:0]             rem
);

   import icfl_pkg::*;

   localparam int CNT_W = $clog2(DIGITS);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] val_ff, val_in;
   logic [BW:0]      rem_ff, rem_in;

   always_comb begin
      logic [BW:0] r;
      r       = rem_ff;
      for (int k = 0; k < DIGIT_W; k++) begin
         r = {r[BW-1:0], val_ff[NUM_W-1-k]};
         if (r >= (BW+1)'(BUCKETS)) begin
            r = r - (BW+1)'(BUCKETS);
         end
      end
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      rem_in  = rem_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         val_in  = cmd.value;
         rem_in  = '0;
      end else if (busy_ff) begin
         val_in = val_ff << DIGIT_W;
         rem_in = r;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIGITS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      val_ff <= val_in;
      rem_ff <= rem_in;
   end

   assign busy = busy_ff;
   assign rem  = rem_ff[BW-1:0];

endmodule

`default_nettype wire

// ===== rtl/icfl_ctrl.sv =====
// ----------------------------------------------------------------------------
// icfl_ctrl: command sequencer of the inode cache table
// Walks bucket chains and patches chain and free-list links in RAM,
// one read-modify-write at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module icfl_ctrl #(
   parameter int ENTRIES = 64,
   parameter int BUCKETS = 16,
   parameter int IW      = $clog2(ENTRIES + 1),
   parameter int EW      = $clog2(ENTRIES),
   parameter int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
   parameter int LW      = 4 * IW + 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire icfl_pkg::req_type     req_data,
   output icfl_pkg::fin_type          fin,
   input  wire logic                  rsp_free,
   output icfl_pkg::mod_cmd_type      mod_cmd,
   input  wire logic                  mod_busy,
   input  wire logic [BW-1:0]         mod_rem,
   output logic                       link_we,
   output logic [EW-1:0]              link_waddr,
   output logic [LW-1:0]              link_wdata,
   output logic [EW-1:0]              link_raddr,
   input  wire logic [LW-1:0]         link_rdata,
   output logic                       tag_we,
   output logic [icfl_pkg::NUM_W-1:0] tag_wdata,
   input  wire logic [icfl_pkg::NUM_W-1:0] tag_rdata,
   output logic                       bkt_we,
   output logic [BW-1:0]              bkt_waddr,
   output logic [IW-1:0]              bkt_wdata,
   output logic [BW-1:0]              bkt_raddr,
   input  wire logic [IW-1:0]         bkt_rdata
);

   import icfl_pkg::*;

   localparam int MAXN = (ENTRIES > BUCKETS) ? ENTRIES : BUCKETS;
   localparam int CW   = $clog2(MAXN);
   localparam logic [IW-1:0] NIL = IW'(ENTRIES);

   typedef struct packed {
      logic [IW-1:0] cn;
      logic [IW-1:0] cp;
      logic [IW-1:0] fn;
      logic [IW-1:0] fp;
      logic          tbl;
      logic          onf;
   } link_type;

   typedef enum logic [4:0] {
      S_CLR, S_IDLE, S_LK_MOD, S_LK_BKT, S_LK_CMP, S_AL_LD, S_FU_E,
      S_INS_CHK, S_INS_MOD, S_INS_BKT, S_INS_H, S_RM_CHK, S_RL_CHK,
      S_RL_TAIL, S_TU_START, S_TU_MOD, S_TU_BKT, S_NB_P, S_NB_N, S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [NUM_W-1:0] tag_ff, tag_in;
   logic [IW-1:0]    e_ff, e_in;
   logic [IW-1:0]    p_ff, p_in;
   logic [IW-1:0]    n_ff, n_in;
   logic [IW-1:0]    fhead_ff, fhead_in;
   logic [IW-1:0]    ftail_ff, ftail_in;
   logic [IW-1:0]    res_ff, res_in;
   logic [BW-1:0]    b_ff, b_in;
   logic [CW-1:0]    clr_ff, clr_in;
   link_type         lk_ff, lk_in;
   logic             chain_ff, chain_in;
   logic             ok_ff, ok_in;
   fin_type          fin_ff, fin_in;

   always_comb begin
      link_type    lnk;
      link_type    w;
      logic [31:0] idx32;
      logic [31:0] clr32;
      logic [31:0] res32;
      lnk        = link_type'(link_rdata);
      w          = lnk;
      idx32      = 32'(req_data.entry_index);
      clr32      = 32'(clr_ff);
      res32      = 32'(res_ff);
      state_in   = state_ff;
      num_in     = num_ff;
      tag_in     = tag_ff;
      e_in       = e_ff;
      p_in       = p_ff;
      n_in       = n_ff;
      fhead_in   = fhead_ff;
      ftail_in   = ftail_ff;
      res_in     = res_ff;
      b_in       = b_ff;
      clr_in     = clr_ff;
      lk_in      = lk_ff;
      chain_in   = chain_ff;
      ok_in      = ok_ff;
      fin_in     = '0;
      link_we    = 1'b0;
      link_waddr = e_ff[EW-1:0];
      link_wdata = '0;
      link_raddr = e_ff[EW-1:0];
      tag_we     = 1'b0;
      tag_wdata  = num_ff;
      bkt_we     = 1'b0;
      bkt_waddr  = b_ff;
      bkt_wdata  = NIL;
      bkt_raddr  = b_ff;
      mod_cmd.start = 1'b0;
      mod_cmd.value = (state_ff == S_TU_START) ? tag_ff : req_data.inode_number;

      case (state_ff)
         S_CLR: begin
            // write reset links of one entry and one bucket per cycle
            w.cn = NIL;
            w.cp = NIL;
            w.fn = IW'(clr32 + 32'd1);
            w.fp = (clr32 == 32'd0) ? NIL : IW'(clr32 - 32'd1);
            w.tbl = 1'b0;
            w.onf = 1'b1;
            link_we    = (clr32 < ENTRIES);
            link_waddr = clr_ff[EW-1:0];
            link_wdata = w;
            bkt_we     = (clr32 < BUCKETS);
            bkt_waddr  = clr_ff[BW-1:0];
            bkt_wdata  = NIL;
            if (clr32 == MAXN - 1) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               num_in = req_data.inode_number;
               e_in   = idx32[IW-1:0];
               ok_in  = 1'b0;
               res_in = '0;
               case (req_data.command)
                  CMD_LOOKUP: begin
                     if (req_data.inode_number == '0) begin
                        state_in = S_DONE;
                     end else begin
                        mod_cmd.start = 1'b1;
                        state_in      = S_LK_MOD;
                     end
                  end
                  CMD_ALLOC: begin
                     if (fhead_ff == NIL) begin
                        state_in = S_DONE;
                     end else begin
                        e_in       = fhead_ff;
                        link_raddr = fhead_ff[EW-1:0];
                        state_in   = S_AL_LD;
                     end
                  end
                  CMD_INSERT: begin
                     if (idx32 >= ENTRIES || req_data.inode_number == '0) begin
                        state_in = S_DONE;
                     end else begin
                        link_raddr    = idx32[EW-1:0];
                        mod_cmd.start = 1'b1;
                        state_in      = S_INS_CHK;
                     end
                  end
                  CMD_REMOVE: begin
                     if (idx32 >= ENTRIES) begin
                        state_in = S_DONE;
                     end else begin
                        link_raddr = idx32[EW-1:0];
                        state_in   = S_RM_CHK;
                     end
                  end
                  CMD_RELEASE: begin
                     if (idx32 >= ENTRIES) begin
                        state_in = S_DONE;
                     end else begin
                        link_raddr = idx32[EW-1:0];
                        state_in   = S_RL_CHK;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_LK_MOD: begin
            if (!mod_busy) begin
               bkt_raddr = mod_rem;
               b_in      = mod_rem;
               state_in  = S_LK_BKT;
            end
         end
         S_LK_BKT: begin
            if (bkt_rdata == NIL) begin
               state_in = S_DONE;
            end else begin
               e_in       = bkt_rdata;
               link_raddr = bkt_rdata[EW-1:0];
               state_in   = S_LK_CMP;
            end
         end
         S_LK_CMP: begin
            if (tag_rdata == num_ff) begin
               ok_in  = 1'b1;
               res_in = e_ff;
               lk_in  = lnk;
               state_in = lnk.onf ? S_FU_E : S_DONE;
            end else if (lnk.cn == NIL) begin
               state_in = S_DONE;
            end else begin
               e_in       = lnk.cn;
               link_raddr = lnk.cn[EW-1:0];
            end
         end
         S_AL_LD: begin
            lk_in    = lnk;
            ok_in    = 1'b1;
            res_in   = e_ff;
            state_in = S_FU_E;
         end
         S_FU_E: begin
            // take the entry off the free list, then patch its neighbors
            w     = lk_ff;
            w.fn  = NIL;
            w.fp  = NIL;
            w.onf = 1'b0;
            link_we    = 1'b1;
            link_wdata = w;
            if (fhead_ff == e_ff) fhead_in = lk_ff.fn;
            if (ftail_ff == e_ff) ftail_in = lk_ff.fp;
            p_in     = lk_ff.fp;
            n_in     = lk_ff.fn;
            chain_in = 1'b0;
            if (lk_ff.fp != NIL) begin
               link_raddr = lk_ff.fp[EW-1:0];
               state_in   = S_NB_P;
            end else if (lk_ff.fn != NIL) begin
               link_raddr = lk_ff.fn[EW-1:0];
               state_in   = S_NB_N;
            end else begin
               state_in = S_DONE;
            end
         end
         S_NB_P: begin
            if (chain_ff) w.cn = n_ff;
            else          w.fn = n_ff;
            link_we    = 1'b1;
            link_waddr = p_ff[EW-1:0];
            link_wdata = w;
            if (n_ff != NIL) begin
               link_raddr = n_ff[EW-1:0];
               state_in   = S_NB_N;
            end else begin
               state_in = S_DONE;
            end
         end
         S_NB_N: begin
            if (chain_ff) w.cp = p_ff;
            else          w.fp = p_ff;
            link_we    = 1'b1;
            link_waddr = n_ff[EW-1:0];
            link_wdata = w;
            state_in   = S_DONE;
         end
         S_INS_CHK: begin
            if (lnk.tbl) begin
               state_in = S_DONE;
            end else begin
               lk_in    = lnk;
               state_in = S_INS_MOD;
            end
         end
         S_INS_MOD: begin
            if (!mod_busy) begin
               bkt_raddr = mod_rem;
               b_in      = mod_rem;
               state_in  = S_INS_BKT;
            end
         end
         S_INS_BKT: begin
            // tag the entry and push it on the bucket head
            w     = lk_ff;
            w.cp  = NIL;
            w.cn  = bkt_rdata;
            w.tbl = 1'b1;
            link_we    = 1'b1;
            link_wdata = w;
            tag_we     = 1'b1;
            bkt_we     = 1'b1;
            bkt_wdata  = e_ff;
            ok_in      = 1'b1;
            n_in       = bkt_rdata;
            if (bkt_rdata != NIL) begin
               link_raddr = bkt_rdata[EW-1:0];
               state_in   = S_INS_H;
            end else begin
               state_in = S_DONE;
            end
         end
         S_INS_H: begin
            w.cp       = e_ff;
            link_we    = 1'b1;
            link_waddr = n_ff[EW-1:0];
            link_wdata = w;
            state_in   = S_DONE;
         end
         S_RM_CHK: begin
            if (!lnk.tbl) begin
               state_in = S_DONE;
            end else begin
               lk_in    = lnk;
               tag_in   = tag_rdata;
               state_in = S_TU_START;
            end
         end
         S_RL_CHK: begin
            if (lnk.onf) begin
               state_in = S_DONE;
            end else begin
               // append at the free-list tail
               tag_in = tag_rdata;
               w.fn   = NIL;
               w.fp   = ftail_ff;
               w.onf  = 1'b1;
               link_we    = 1'b1;
               link_wdata = w;
               lk_in      = w;
               ok_in      = 1'b1;
               ftail_in   = e_ff;
               n_in       = ftail_ff;
               if (ftail_ff != NIL) begin
                  link_raddr = ftail_ff[EW-1:0];
                  state_in   = S_RL_TAIL;
               end else begin
                  fhead_in = e_ff;
                  state_in = lnk.tbl ? S_TU_START : S_DONE;
               end
            end
         end
         S_RL_TAIL: begin
            w.fn       = e_ff;
            link_we    = 1'b1;
            link_waddr = n_ff[EW-1:0];
            link_wdata = w;
            state_in   = lk_ff.tbl ? S_TU_START : S_DONE;
         end
         S_TU_START: begin
            mod_cmd.start = 1'b1;
            state_in      = S_TU_MOD;
         end
         S_TU_MOD: begin
            if (!mod_busy) begin
               bkt_raddr = mod_rem;
               b_in      = mod_rem;
               state_in  = S_TU_BKT;
            end
         end
         S_TU_BKT: begin
            // drop the entry from its chain
            bkt_we    = (bkt_rdata == e_ff);
            bkt_wdata = lk_ff.cn;
            w     = lk_ff;
            w.cn  = NIL;
            w.cp  = NIL;
            w.tbl = 1'b0;
            link_we    = 1'b1;
            link_wdata = w;
            ok_in      = 1'b1;
            p_in       = lk_ff.cp;
            n_in       = lk_ff.cn;
            chain_in   = 1'b1;
            if (lk_ff.cp != NIL) begin
               link_raddr = lk_ff.cp[EW-1:0];
               state_in   = S_NB_P;
            end else if (lk_ff.cn != NIL) begin
               link_raddr = lk_ff.cn[EW-1:0];
               state_in   = S_NB_N;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               fin_in.valid             = 1'b1;
               fin_in.data.success      = ok_ff;
               fin_in.data.result_entry = res32[IDX_W-1:0];
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff   <= '0;
         fhead_ff <= '0;
         ftail_ff <= IW'(ENTRIES - 1);
         fin_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         fhead_ff <= fhead_in;
         ftail_ff <= ftail_in;
         fin_ff   <= fin_in;
      end
      num_ff   <= num_in;
      tag_ff   <= tag_in;
      e_ff     <= e_in;
      p_ff     <= p_in;
      n_ff     <= n_in;
      res_ff   <= res_in;
      b_ff     <= b_in;
      lk_ff    <= lk_in;
      chain_ff <= chain_in;
      ok_ff    <= ok_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign fin       = fin_ff;

endmodule

`default_nettype wire

// ===== test/tb_inode_cache_hash_free_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_inode_cache_hash_free_list: self-checking bench for the inode cache table
// Drives lookup, allocate, insert, remove and release words through random
// idling and back-pressure. Each response is checked against a predictor that
// keeps its own copy of the chains and the free list.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_inode_cache_hash_free_list;
   import icfl_pkg::*;

   localparam int ENTRIES  = 64;
   localparam int BUCKETS  = 16;
   localparam int NIL      = ENTRIES;
   localparam int LIMIT    = 1000000;
   localparam int RAND_ITEMS = 1000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   inode_cache_hash_free_list #(.ENTRIES(ENTRIES), .BUCKETS(BUCKETS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   // Shadow copy of the table and free list.
   logic [31:0] tag_mem   [ENTRIES];
   bit          member    [ENTRIES];
   int          ch_next   [ENTRIES];
   int          ch_prev   [ENTRIES];
   int          bkt_head  [BUCKETS];
   int          fr_next   [ENTRIES];
   int          fr_prev   [ENTRIES];
   bit          is_free   [ENTRIES];
   int          fr_head, fr_tail;

   rsp_type     pending_rsp[$];
   int          errors = 0;
   int          cycles = 0;
   int          rsp_seen = 0;
   int          hits = 0;
   bit          idle_en = 1'b1;   // random idling on both sides
   bit          long_hold = 1'b0; // receiver holds off for a long stretch

   function automatic void shadow_reset();
      for (int i = 0; i < ENTRIES; i++) begin
         tag_mem[i] = '0; member[i] = 0; ch_next[i] = NIL; ch_prev[i] = NIL;
         fr_next[i] = i + 1; fr_prev[i] = (i == 0) ? NIL : i - 1; is_free[i] = 1;
      end
      for (int b = 0; b < BUCKETS; b++) bkt_head[b] = NIL;
      fr_head = 0; fr_tail = ENTRIES - 1;
   endfunction

   function automatic void free_take(int e);
      int p, n;
      p = fr_prev[e]; n = fr_next[e];
      if (fr_head == e) fr_head = n;
      if (fr_tail == e) fr_tail = p;
      if (p < ENTRIES) fr_next[p] = n;
      if (n < ENTRIES) fr_prev[n] = p;
      fr_prev[e] = NIL; fr_next[e] = NIL; is_free[e] = 0;
   endfunction

   function automatic void chain_take(int e);
      int b, p, n;
      b = tag_mem[e] % BUCKETS; p = ch_prev[e]; n = ch_next[e];
      if (bkt_head[b] == e) bkt_head[b] = n;
      if (p < ENTRIES) ch_next[p] = n;
      if (n < ENTRIES) ch_prev[n] = p;
      ch_prev[e] = NIL; ch_next[e] = NIL; member[e] = 0;
   endfunction

   // Apply one request word to the shadow state; return the response.
   function automatic rsp_type cache_apply(req_type w);
      rsp_type r;
      int e, c, steps, b;
      r = '0; e = w.entry_index;
      case (w.command)
         CMD_LOOKUP: if (w.inode_number != 0) begin
            c = bkt_head[w.inode_number % BUCKETS]; steps = 0;
            while (c < ENTRIES && steps < ENTRIES && tag_mem[c] != w.inode_number) begin
               c = ch_next[c]; steps++;
            end
            if (c < ENTRIES && tag_mem[c] == w.inode_number) begin
               if (is_free[c]) free_take(c);
               r.success = 1; r.result_entry = c[IDX_W-1:0];
            end
         end
         CMD_ALLOC: if (fr_head < ENTRIES) begin
            r.success = 1; r.result_entry = fr_head[IDX_W-1:0];
            free_take(fr_head);
         end
         CMD_INSERT: if (w.inode_number != 0 && !member[e]) begin
            b = w.inode_number % BUCKETS;
            tag_mem[e] = w.inode_number; ch_prev[e] = NIL; ch_next[e] = bkt_head[b];
            if (bkt_head[b] < ENTRIES) ch_prev[bkt_head[b]] = e;
            bkt_head[b] = e; member[e] = 1; r.success = 1;
         end
         CMD_REMOVE: if (member[e]) begin
            chain_take(e); r.success = 1;
         end
         CMD_RELEASE: if (!is_free[e]) begin
            fr_next[e] = NIL; fr_prev[e] = fr_tail;
            if (fr_tail < ENTRIES) fr_next[fr_tail] = e; else fr_head = e;
            fr_tail = e; is_free[e] = 1;
            if (member[e]) chain_take(e);
            r.success = 1;
         end
         default: ;
      endcase
      return r;
   endfunction

   // Send one word; predict its response once it is accepted. Valid stays
   // high after acceptance until the next word or an idle gap replaces it.
   task automatic send_word(logic [2:0] cmd, logic [31:0] num, logic [5:0] idx);
      req_type w;
      w.command = cmd; w.inode_number = num; w.entry_index = idx;
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      pending_rsp.push_back(cache_apply(w));
   endtask

   task automatic drain_rsp();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // Receiver stall: random bursts, or one long hold-off.
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold = 1'b0;
         end else if (idle_en && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Response checker.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            $error("response with none expected: %p", rsp_data);
            errors++;
         end else begin
            rsp_type x;
            x = pending_rsp.pop_front();
            if (x.success && x.result_entry != 0) hits++;
            if (rsp_data.success !== x.success) begin
               $error("success: expected %0d actual %0d", x.success, rsp_data.success);
               errors++;
            end
            if (rsp_data.result_entry !== x.result_entry) begin
               $error("result_entry: expected %0d actual %0d",
                      x.result_entry, rsp_data.result_entry);
               errors++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_inode_cache_hash_free_list: FAIL");
         $finish;
      end
   end

   // Random number, mostly from small sets of values so numbers recur; one case in four is fully random.
   function automatic logic [31:0] pick_number();
      logic [31:0] n;
      case ($urandom_range(0, 3))
         0: n = $urandom();
         1: n = {28'($urandom_range(0, 3)), 4'h0} | $urandom_range(0, 15);
         2: n = ($urandom_range(0, 1) ? 32'hFFFF_FFF0 : 32'h0) | $urandom_range(0, 15);
         default: n = $urandom_range(1, 40);
      endcase
      return n;
   endfunction

   // Extremes and special cases.
   task automatic test_directed();
      send_word(CMD_LOOKUP, 32'd0, 6'd0);           // number zero
      send_word(CMD_INSERT, 32'd0, 6'd5);           // insert with zero
      send_word(CMD_REMOVE, 32'd7, 6'd5);           // remove non-member
      send_word(CMD_RELEASE, 32'd0, 6'd3);          // release already free
      send_word(CMD_ALLOC, 32'd0, 6'd0);
      send_word(CMD_INSERT, 32'hFFFF_FFFF, 6'd63);
      send_word(CMD_INSERT, 32'hFFFF_FFFF, 6'd63);  // insert of a member
      send_word(CMD_INSERT, 32'h0000_000F, 6'd0);   // same bucket
      send_word(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0);   // hit, unlinks from free list
      send_word(CMD_LOOKUP, 32'h0000_000F, 6'd0);
      send_word(CMD_LOOKUP, 32'h0000_001F, 6'd0);   // miss in a live chain
      send_word(CMD_REMOVE, 32'd0, 6'd63);
      send_word(CMD_RELEASE, 32'd0, 6'd0);          // release of a member unlinks it
      send_word(CMD_LOOKUP, 32'h0000_000F, 6'd0);
      for (logic [2:0] c = 3'd5; c != 3'd0; c++)    // unknown commands
         send_word(c, $urandom(), 6'($urandom()));
      drain_rsp();
   endtask

   // Empty the free list, then refill it.
   task automatic test_exhaust();
      repeat (ENTRIES + 2) send_word(CMD_ALLOC, $urandom(), 6'($urandom()));
      for (int i = ENTRIES - 1; i >= 0; i--) send_word(CMD_RELEASE, '0, 6'(i));
      drain_rsp();
   endtask

   // Receiver holds off long while the sender keeps offering.
   task automatic test_backpressure();
      long_hold = 1'b1;
      repeat (40) send_word(CMD_ALLOC, '0, '0);
      repeat (40) send_word(CMD_RELEASE, '0, 6'($urandom()));
      drain_rsp();
   endtask

   // Mostly well-formed allocate / insert / lookup / remove / release traffic.
   task automatic test_random(int count, bit idle);
      int e;
      idle_en = idle;
      for (int i = 0; i < count; i++) begin
         e = $urandom_range(0, ENTRIES - 1);
         case ($urandom_range(0, 9))
            0, 1: send_word(CMD_ALLOC, $urandom(), 6'($urandom()));
            2, 3: send_word(CMD_INSERT, pick_number(), 6'(e));
            4, 5, 6: send_word(CMD_LOOKUP, pick_number(), 6'($urandom()));
            7: send_word(CMD_REMOVE, $urandom(), 6'(e));
            8: send_word(CMD_RELEASE, $urandom(), 6'(e));
            default: send_word(3'($urandom()), $urandom(), 6'($urandom()));
         endcase
         if (i == count / 2) drain_rsp(); // sender pauses until all are back
      end
      drain_rsp();
   endtask

   initial begin
      shadow_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_exhaust();
      test_backpressure();
      test_random(RAND_ITEMS - 200, 1'b1);
      test_random(200, 1'b0);
      repeat (50) @(posedge clock);
      $display("covered %0d responses, %0d nonzero-entry hits, in %0d cycles",
               rsp_seen, hits, cycles);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("tb_inode_cache_hash_free_list: PASS");
      end else begin
         $display("tb_inode_cache_hash_free_list: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
